>>> hw/rtl/cse_pkg.sv
// Shared types, constants and round functions for the ChaCha20 byte stream block.
// No dependencies; every other RTL module imports this package.
`default_nettype none
package cse_pkg;

	// ChaCha20 "expand 32-byte k" constants
	localparam logic [31:0] Sigma0 = 32'h6170_7865;
	localparam logic [31:0] Sigma1 = 32'h3320_646e;
	localparam logic [31:0] Sigma2 = 32'h7962_2d32;
	localparam logic [31:0] Sigma3 = 32'h6b20_6574;

	localparam int DoubleRounds = 10;
	// two half quarter rounds per quarter round, column and diagonal per double round
	localparam int HalfSteps    = DoubleRounds * 4;
	localparam int StepW        = $clog2(HalfSteps);
	localparam int QDepth       = 4;
	localparam int QPtrW        = $clog2(QDepth);

	typedef logic [31:0]       word_t;
	typedef word_t [15:0]      words16_t;

	typedef enum logic [2:0] {
		REG_KEY_0      = 3'd0,
		REG_KEY_1      = 3'd1,
		REG_KEY_2      = 3'd2,
		REG_KEY_3      = 3'd3,
		REG_NONCE_LOW  = 3'd4,
		REG_NONCE_HIGH = 3'd5,
		REG_INIT_CTR   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		word_t [7:0] key;
		word_t [2:0] nonce;
	} key_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       new_blk;   // byte sits at position 0: a fresh block is due
		logic [5:0] pos;
		word_t      counter;
	} q_entry_t;

	typedef struct packed {
		logic  start;
		word_t counter;
	} core_req_t;

	typedef struct packed {
		logic     done;
		words16_t words;
	} core_rsp_t;

	typedef enum logic [1:0] {
		CR_IDLE,
		CR_ROUND,
		CR_FINAL
	} core_state_t;

	typedef enum logic {
		BK_READY,
		BK_GEN
	} back_state_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} qr_t;

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// Half a quarter round: two chained adds. second selects the 8/7 rotate half.
	function automatic qr_t half_qr(input word_t a, input word_t b, input word_t c,
			input word_t d, input logic second);
		qr_t r;
		r.a = a + b;
		r.d = second ? rotl(d ^ r.a, 8) : rotl(d ^ r.a, 16);
		r.c = c + r.d;
		r.b = second ? rotl(b ^ r.c, 7) : rotl(b ^ r.c, 12);
		half_qr = r;
	endfunction

	function automatic words16_t init_words(input key_t k, input word_t counter);
		words16_t w;
		w[0] = Sigma0;
		w[1] = Sigma1;
		w[2] = Sigma2;
		w[3] = Sigma3;
		for (int i = 0; i < 8; i++) begin
			w[4 + i] = k.key[i];
		end
		w[12] = counter;
		w[13] = k.nonce[0];
		w[14] = k.nonce[1];
		w[15] = k.nonce[2];
		init_words = w;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cse_in_if.sv
// Input channel of the ChaCha20 byte stream block: valid/ready plus one input word.
// Depends on nothing.
`default_nettype none
interface cse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] plain_byte;
	logic       last_of_message;

	modport source(output valid, plain_byte, last_of_message, input ready);
	modport sink(input valid, plain_byte, last_of_message, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cse_out_if.sv
// Output channel of the ChaCha20 byte stream block: valid/ready plus one result word.
// Depends on nothing.
`default_nettype none
interface cse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] cipher_byte;
	logic       last_out;

	modport source(output valid, cipher_byte, last_out, input ready);
	modport sink(input valid, cipher_byte, last_out, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/chacha20_stream_encrypt.sv
// ChaCha20 (RFC 8439) byte stream transform: each input word is one byte that
// comes back XORed with the next keystream byte, with last_out copying the
// last-of-message flag. Key, nonce and initial counter are written through the
// plain write port (index 0..3 key_0..key_3, 4 nonce_low, 5 nonce_high,
// 6 initial_counter; index 7 is ignored) and must be stable while words are in
// flight. A byte at block position 0 makes the core compute a fresh block from
// the registers and counter = initial_counter + blocks so far (mod 2^32); the
// other 63 bytes of a block flow at one word per cycle unless the output stalls.
// Block generation holds the first byte of a block through 1 load, 40
// half-quarter-round steps of the shared round datapath and 1 feed-forward add
// before it can be popped. A four-entry queue lets the input side keep
// accepting while the core works, and the output register lets the next block
// be generated while the previous result waits. The last-of-message flag
// returns position and block count to zero for the next message.
`default_nettype none
module chacha20_stream_encrypt
	import cse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wen,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	cse_in_if.sink           plain,
	cse_out_if.source        cipher
);

	// configuration registers
	key_t      key_q;
	word_t     init_ctr_q;

	// front -> queue
	logic      push_valid;
	logic      push_ready;
	q_entry_t  push_entry;

	// queue -> back
	logic      head_valid;
	q_entry_t  head;
	logic      pop;

	// back <-> core
	core_req_t req;
	core_rsp_t rsp;

	// Config writes: 64-bit writes fill two words; nonce_high and init_ctr keep only bits 31:0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q      <= '0;
			init_ctr_q <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_KEY_0:      key_q.key[1:0] <= cfg_wdata;
				REG_KEY_1:      key_q.key[3:2] <= cfg_wdata;
				REG_KEY_2:      key_q.key[5:4] <= cfg_wdata;
				REG_KEY_3:      key_q.key[7:6] <= cfg_wdata;
				REG_NONCE_LOW:  key_q.nonce[1:0] <= cfg_wdata;
				REG_NONCE_HIGH: key_q.nonce[2] <= cfg_wdata[31:0];
				REG_INIT_CTR:   init_ctr_q <= cfg_wdata[31:0];
				default: ;  // unused index: write dropped
			endcase
		end
	end

	// Front: classify bytes by block position
	cse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.plain      (plain),
		.init_ctr   (init_ctr_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Decoupling queue
	cse_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	// Back: keystream XOR and result register
	cse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.req        (req),
		.rsp        (rsp),
		.cipher     (cipher)
	);

	// Block function, also holds the current keystream block
	cse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_q),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire

>>> hw/rtl/cse_queue.sv
// Short FIFO of classified bytes between front and back.
// Depends on cse_pkg.
`default_nettype none
module cse_queue
	import cse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire q_entry_t push_entry,
	output logic          head_valid,
	output q_entry_t      head,
	input  wire logic     pop
);

	q_entry_t           mem_q [QDepth];
	logic [QPtrW-1:0]   wr_ptr_q;
	logic [QPtrW-1:0]   rd_ptr_q;
	logic [QPtrW:0]     count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != (QPtrW+1)'(QDepth));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cse_front.sv
// Front end: accepts input words, tracks byte position and block count,
// tags each byte with its position and block counter. Depends on cse_pkg.
`default_nettype none
module cse_front
	import cse_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	cse_in_if.sink     plain,
	input  wire word_t init_ctr,
	output logic       push_valid,
	input  wire logic  push_ready,
	output q_entry_t   push_entry
);

	logic [5:0] pos_q;
	word_t      blocks_q;
	logic       accept;

	assign plain.ready = push_ready;
	assign push_valid  = plain.valid;
	assign accept      = plain.valid && push_ready;

	always_comb begin
		push_entry.data    = plain.plain_byte;
		push_entry.last    = plain.last_of_message;
		push_entry.new_blk = (pos_q == '0);
		push_entry.pos     = pos_q;
		push_entry.counter = init_ctr + blocks_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			blocks_q <= '0;
		end else if (accept) begin
			if (plain.last_of_message) begin
				pos_q    <= '0;
				blocks_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == '1) begin
					blocks_q <= blocks_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cse_core.sv
// ChaCha20 block function: one half quarter round on all four lanes per cycle,
// then the feed-forward add. Holds the current keystream block. Depends on cse_pkg.
`default_nettype none
module cse_core
	import cse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire key_t      key,
	input  wire core_req_t req,
	output core_rsp_t      rsp
);

	core_state_t      state_q;
	core_state_t      state_d;
	words16_t         w_q;
	words16_t         w_rnd;
	word_t            ctr_q;
	logic [StepW-1:0] step_q;
	logic             last_step;
	words16_t         init_w;

	// step bit 0: which half of the quarter round, bit 1: column or diagonal
	always_comb begin
		logic [1:0] jb;
		logic [1:0] jc;
		logic [1:0] jd;
		qr_t        r;
		w_rnd = w_q;
		for (int j = 0; j < 4; j++) begin
			jb = step_q[1] ? 2'(j + 1) : 2'(j);
			jc = step_q[1] ? 2'(j + 2) : 2'(j);
			jd = step_q[1] ? 2'(j + 3) : 2'(j);
			r  = half_qr(w_q[j], w_q[{2'b01, jb}], w_q[{2'b10, jc}], w_q[{2'b11, jd}],
				step_q[0]);
			w_rnd[j]           = r.a;
			w_rnd[{2'b01, jb}] = r.b;
			w_rnd[{2'b10, jc}] = r.c;
			w_rnd[{2'b11, jd}] = r.d;
		end
	end

	assign last_step = (step_q == StepW'(HalfSteps - 1));
	assign init_w    = init_words(key, ctr_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CR_IDLE:  if (req.start) state_d = CR_ROUND;
			CR_ROUND: if (last_step) state_d = CR_FINAL;
			CR_FINAL: state_d = CR_IDLE;
			default:  state_d = CR_IDLE;
		endcase
	end

	always_comb begin
		rsp.done  = (state_q == CR_FINAL);
		rsp.words = w_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CR_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == CR_ROUND) begin
				step_q <= last_step ? '0 : step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			CR_IDLE: begin
				if (req.start) begin
					w_q   <= init_words(key, req.counter);
					ctr_q <= req.counter;
				end
			end
			CR_ROUND: w_q <= w_rnd;
			CR_FINAL: begin
				for (int i = 0; i < 16; i++) begin
					w_q[i] <= w_q[i] + init_w[i];
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/cse_back.sv
// Back end: pops queued bytes, asks the core for a block at each block start,
// XORs in the keystream byte and holds the result word. Depends on cse_pkg.
`default_nettype none
module cse_back
	import cse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      head_valid,
	input  wire q_entry_t  head,
	output logic           pop,
	output core_req_t      req,
	input  wire core_rsp_t rsp,
	cse_out_if.source      cipher
);

	back_state_t state_q;
	back_state_t state_d;
	logic        fresh_q;    // block for the head byte already generated
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q;
	logic        slot_free;
	logic        need_blk;
	word_t       ks_word;
	word_t       ks_shift;

	assign slot_free = !ovalid_q || cipher.ready;
	assign need_blk  = head_valid && head.new_blk && !fresh_q;
	assign ks_word   = rsp.words[head.pos[5:2]];
	assign ks_shift  = ks_word >> {head.pos[1:0], 3'b000};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_READY: if (need_blk) state_d = BK_GEN;
			BK_GEN:   if (rsp.done) state_d = BK_READY;
			default:  state_d = BK_READY;
		endcase
	end

	always_comb begin
		req.start   = (state_q == BK_READY) && need_blk;
		req.counter = head.counter;
		pop         = (state_q == BK_READY) && head_valid && !need_blk && slot_free;
	end

	assign cipher.valid       = ovalid_q;
	assign cipher.cipher_byte = obyte_q;
	assign cipher.last_out    = olast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_READY;
			fresh_q  <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_GEN && rsp.done) begin
				fresh_q <= 1'b1;
			end else if (pop) begin
				fresh_q <= 1'b0;
			end
			if (pop) begin
				ovalid_q <= 1'b1;
			end else if (cipher.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			obyte_q <= head.data ^ ks_shift[7:0];
			olast_q <= head.last;
		end
	end

endmodule
`default_nettype wire
